// File: rtl/pidt_pkg.sv
`timescale 1ns / 1ps
// pidt_pkg: shared widths, control-word types and register codes for the pid unit
// no dependencies; imported by every module of the block

package pidt_pkg;

    localparam int CoefW    = 21;   // q4.16 coefficients
    localparam int ErrW     = 16;
    localparam int TimeW    = 32;
    localparam int OutW     = 16;
    localparam int QW       = 32;   // q16.16 internal terms
    localparam int FracBits = 16;
    localparam int CfgIdxW  = 3;
    localparam int CfgDataW = 32;
    localparam int InDataW  = 48;   // error_in, time_us
    localparam int OutDataW = 16;   // drive
    localparam int StepW    = 4;

    typedef enum logic [CfgIdxW-1:0] {
        CFG_PROP_GAIN   = 3'd0,
        CFG_INTEG_COEF  = 3'd1,
        CFG_DERIV_COEF  = 3'd2,
        CFG_WINDUP_COEF = 3'd3,
        CFG_FILTER_COEF = 3'd4,
        CFG_PERIOD_US   = 3'd5,
        CFG_OUT_MIN     = 3'd6,
        CFG_OUT_MAX     = 3'd7
    } t_cfg_idx;

    typedef enum logic {
        OP_UPDATE = 1'b0,
        OP_CLEAR  = 1'b1
    } t_item_op;

    typedef struct packed {
        logic signed [CoefW-1:0] prop_gain;
        logic signed [CoefW-1:0] integ_coef;
        logic signed [CoefW-1:0] deriv_coef;
        logic signed [CoefW-1:0] windup_coef;
        logic signed [CoefW-1:0] filter_coef;
        logic        [TimeW-1:0] period_us;
        logic signed [OutW-1:0]  out_min;
        logic signed [OutW-1:0]  out_max;
    } t_cfg;

    // multiplier operand selects
    typedef enum logic [2:0] {
        MA_PROP   = 3'd0,
        MA_INTEG  = 3'd1,
        MA_DERIV  = 3'd2,
        MA_WINDUP = 3'd3,
        MA_FILTER = 3'd4
    } t_mul_a;

    typedef enum logic [2:0] {
        MB_ERR   = 3'd0,
        MB_ESUM  = 3'd1,
        MB_EDIFF = 3'd2,
        MB_DTERM = 3'd3,
        MB_AWSUM = 3'd4
    } t_mul_b;

    typedef enum logic [3:0] {
        ALU_NOP    = 4'd0,
        ALU_CHECK  = 4'd1,
        ALU_P_LOAD = 4'd2,
        ALU_I_ADD  = 4'd3,
        ALU_D_RND  = 4'd4,
        ALU_D_ADD  = 4'd5,
        ALU_SUM    = 4'd6,
        ALU_AW     = 4'd7,
        ALU_I_WADD = 4'd8,
        ALU_COMMIT = 4'd9,
        ALU_HOLD   = 4'd10
    } t_alu_op;

    typedef enum logic {
        JMP_NONE = 1'b0,
        JMP_SKIP = 1'b1
    } t_jmp;

    typedef struct packed {
        logic             mul_en;
        t_mul_a           mul_a;
        t_mul_b           mul_b;
        t_alu_op          alu;
        t_jmp             jmp;
        logic [StepW-1:0] target;
        logic             done;
    } t_ctrl;

    typedef struct packed {
        logic skip;   // clear item or too early
    } t_stat;

    typedef struct packed {
        logic signed [OutW-1:0] drive;
        logic                   updated;
    } t_result;

endpackage

// File: rtl/pidt_seq.sv
`timescale 1ns / 1ps
// pidt_seq: step counter and microprogram rom of the pid unit
// depends on pidt_pkg

module pidt_seq (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_start,
    input  logic            i_hold,
    input  pidt_pkg::t_stat i_stat,
    output pidt_pkg::t_ctrl o_ctrl,
    output logic            o_fire,
    output logic            o_idle
);
    import pidt_pkg::*;

    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_RUN  = 2'b10
    } t_seq_state;

    localparam logic [StepW-1:0] StepHold = StepW'(11);

    t_seq_state       r_state, n_state;
    logic [StepW-1:0] r_step, n_step;
    t_ctrl            w_word;
    logic             w_fire;

    // microprogram: one shared multiplier, result registered before use
    function automatic t_ctrl prog_word(input logic [StepW-1:0] step);
        t_ctrl w;
        w = '0;
        case (step)
            4'd0: begin
                w.alu = ALU_CHECK; w.mul_en = 1'b1; w.mul_a = MA_PROP; w.mul_b = MB_ERR;
                w.jmp = JMP_SKIP; w.target = StepHold;
            end
            4'd1: begin
                w.alu = ALU_P_LOAD; w.mul_en = 1'b1; w.mul_a = MA_INTEG; w.mul_b = MB_ESUM;
            end
            4'd2: begin
                w.alu = ALU_I_ADD; w.mul_en = 1'b1; w.mul_a = MA_FILTER; w.mul_b = MB_DTERM;
            end
            4'd3: begin
                w.alu = ALU_D_RND; w.mul_en = 1'b1; w.mul_a = MA_DERIV; w.mul_b = MB_EDIFF;
            end
            4'd4: w.alu = ALU_D_ADD;
            4'd5: w.alu = ALU_SUM;
            4'd6: w.alu = ALU_AW;
            4'd7: begin
                w.mul_en = 1'b1; w.mul_a = MA_WINDUP; w.mul_b = MB_AWSUM;
            end
            4'd8: w.alu = ALU_I_WADD;
            4'd9: w.alu = ALU_SUM;
            4'd10: begin
                w.alu = ALU_COMMIT; w.done = 1'b1;
            end
            4'd11: begin
                w.alu = ALU_HOLD; w.done = 1'b1;
            end
            default: begin
                w.alu = ALU_HOLD; w.done = 1'b1;
            end
        endcase
        return w;
    endfunction

    always_comb begin
        w_word  = prog_word(r_step);
        w_fire  = (r_state == ST_RUN) && !(w_word.done && i_hold);
        n_state = r_state;
        n_step  = r_step;
        case (r_state)
            ST_IDLE: begin
                if (i_start) begin
                    n_state = ST_RUN;
                    n_step  = '0;
                end
            end
            ST_RUN: begin
                if (w_fire) begin
                    if (w_word.done) begin
                        n_state = ST_IDLE;
                    end else if (w_word.jmp == JMP_SKIP && i_stat.skip) begin
                        n_step = w_word.target;
                    end else begin
                        n_step = r_step + 1'b1;
                    end
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_step  <= '0;
        end else begin
            r_state <= n_state;
            r_step  <= n_step;
        end
    end

    assign o_ctrl = w_word;
    assign o_fire = w_fire;
    assign o_idle = (r_state == ST_IDLE);

endmodule

// File: rtl/pidt_dpath.sv
`timescale 1ns / 1ps
// pidt_dpath: controller state, shared multiplier and saturating alu of the pid unit
// depends on pidt_pkg; driven by the control word from pidt_seq

module pidt_dpath (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  pidt_pkg::t_cfg                 i_cfg,
    input  logic                           i_load,
    input  logic                           i_op,
    input  logic signed [pidt_pkg::ErrW-1:0] i_err,
    input  logic [pidt_pkg::TimeW-1:0]     i_time,
    input  pidt_pkg::t_ctrl                i_ctrl,
    input  logic                           i_fire,
    output pidt_pkg::t_stat                o_stat,
    output pidt_pkg::t_result              o_result
);
    import pidt_pkg::*;

    localparam int MulBW   = ErrW + 17;          // widest b operand: windup sum
    localparam int ProdW   = CoefW + MulBW;
    localparam int AccW    = ProdW - FracBits + 1;
    localparam int WideW   = ProdW + 2;
    localparam int HalfLsb = 1 << (FracBits - 1);

    typedef logic signed [WideW-1:0] t_wide;

    // request captured at accept
    logic                    r_op;
    logic signed [ErrW-1:0]  r_err;
    logic [TimeW-1:0]        r_time;

    // controller state
    logic signed [QW-1:0]    r_i, r_d, r_prev_aw;
    logic signed [ErrW-1:0]  r_prev_err;
    logic signed [OutW-1:0]  r_held;
    logic [TimeW-1:0]        r_prev_time;

    // scratch
    logic signed [QW-1:0]    r_p, r_u, r_aw;
    logic signed [AccW-1:0]  r_acc;
    logic signed [ProdW-1:0] r_prod;

    logic signed [CoefW-1:0] w_mul_a;
    logic signed [MulBW-1:0] w_mul_b;
    logic signed [ProdW-1:0] w_prod;
    logic [TimeW-1:0]        w_elapsed;
    logic signed [QW-1:0]    w_lo, w_hi, w_uc;
    t_wide                   w_rs;
    logic signed [OutW-1:0]  w_drive;

    function automatic logic signed [QW-1:0] sat_q(input t_wide x);
        logic signed [QW-1:0] y;
        if (&x[WideW-1:QW-1] || ~|x[WideW-1:QW-1]) begin
            y = x[QW-1:0];
        end else if (x[WideW-1]) begin
            y = {1'b1, {(QW-1){1'b0}}};
        end else begin
            y = {1'b0, {(QW-1){1'b1}}};
        end
        return y;
    endfunction

    // round half up, then drop the fraction
    function automatic t_wide rnd_q(input t_wide x);
        return (x + t_wide'(HalfLsb)) >>> FracBits;
    endfunction

    always_comb begin
        case (i_ctrl.mul_a)
            MA_PROP:   w_mul_a = i_cfg.prop_gain;
            MA_INTEG:  w_mul_a = i_cfg.integ_coef;
            MA_DERIV:  w_mul_a = i_cfg.deriv_coef;
            MA_WINDUP: w_mul_a = i_cfg.windup_coef;
            MA_FILTER: w_mul_a = i_cfg.filter_coef;
            default:   w_mul_a = '0;
        endcase
        case (i_ctrl.mul_b)
            MB_ERR:   w_mul_b = MulBW'(r_err);
            MB_ESUM:  w_mul_b = MulBW'(r_err) + MulBW'(r_prev_err);
            MB_EDIFF: w_mul_b = MulBW'(r_err) - MulBW'(r_prev_err);
            MB_DTERM: w_mul_b = MulBW'(r_d);
            MB_AWSUM: w_mul_b = MulBW'(r_aw) + MulBW'(r_prev_aw);
            default:  w_mul_b = '0;
        endcase
    end

    assign w_prod = w_mul_a * w_mul_b;

    assign w_elapsed   = r_time - r_prev_time;
    assign o_stat.skip = (r_op == OP_CLEAR) || (w_elapsed < i_cfg.period_us);

    // output limits in q16.16; lower limit tested first
    assign w_lo = $signed({i_cfg.out_min, {FracBits{1'b0}}});
    assign w_hi = $signed({i_cfg.out_max, {FracBits{1'b0}}});

    always_comb begin
        if (r_u < w_lo) begin
            w_uc = w_lo;
        end else if (r_u > w_hi) begin
            w_uc = w_hi;
        end else begin
            w_uc = r_u;
        end
        w_rs = rnd_q(t_wide'(r_u));
        if (w_rs < t_wide'(i_cfg.out_min)) begin
            w_drive = i_cfg.out_min;
        end else if (w_rs > t_wide'(i_cfg.out_max)) begin
            w_drive = i_cfg.out_max;
        end else begin
            w_drive = w_rs[OutW-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_op   <= i_op;
            r_err  <= i_err;
            r_time <= i_time;
        end
        if (i_fire && i_ctrl.mul_en) begin
            r_prod <= w_prod;
        end
        if (i_fire) begin
            case (i_ctrl.alu)
                ALU_P_LOAD: r_p   <= sat_q(t_wide'(r_prod));
                ALU_D_RND:  r_acc <= AccW'(rnd_q(t_wide'(r_prod)));
                ALU_SUM:    r_u   <= sat_q(t_wide'(r_p) + t_wide'(r_i) + t_wide'(r_d));
                ALU_AW:     r_aw  <= sat_q(t_wide'(w_uc) - t_wide'(r_u));
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_i         <= '0;
            r_d         <= '0;
            r_prev_aw   <= '0;
            r_prev_err  <= '0;
            r_held      <= '0;
            r_prev_time <= '0;
        end else if (i_fire) begin
            case (i_ctrl.alu)
                ALU_CHECK: begin
                    if (r_op == OP_CLEAR) begin
                        r_i       <= '0;
                        r_prev_aw <= '0;
                    end
                end
                ALU_I_ADD:  r_i <= sat_q(t_wide'(r_i) + t_wide'(r_prod));
                ALU_D_ADD:  r_d <= sat_q(t_wide'(r_acc) + t_wide'(r_prod));
                ALU_I_WADD: r_i <= sat_q(t_wide'(r_i) + rnd_q(t_wide'(r_prod)));
                ALU_COMMIT: begin
                    r_held      <= w_drive;
                    r_prev_err  <= r_err;
                    r_prev_aw   <= r_aw;
                    r_prev_time <= r_time;
                end
                default: ;
            endcase
        end
    end

    assign o_result.drive   = (i_ctrl.alu == ALU_COMMIT) ? w_drive : r_held;
    assign o_result.updated = (i_ctrl.alu == ALU_COMMIT);

endmodule

// File: rtl/pid_controller_tustin_antiwindup_unit.sv
`timescale 1ns / 1ps
// pid_controller_tustin_antiwindup_unit: top level, stream ports, config registers, result register
// depends on pidt_pkg, pidt_seq, pidt_dpath

// Discrete pid step with tustin integral, filtered derivative, back-calculation
// anti-windup and output clamping. Each request on the slave stream gives exactly one
// result on the master stream. An update request (tuser = 0) runs the control law when
// at least period_us microseconds have passed since the last update that ran (modular
// timestamp difference); otherwise the held output is repeated with updated = 0. A
// clear request (tuser = 1) zeroes the integral and the stored windup term and repeats
// the held output. Timing: one request is worked at a time. An update that runs the
// control law steps through the whole microprogram before the next accept; a skipped
// update or a clear jumps from the check step to the hold step. The run length is set
// by the microprogram, which routes five dependent products through one registered 21x33
// multiplier with a saturating add, round or clamp between products. The result sits in
// an output register, so a waiting master side only stalls the last step of the next
// request. Coefficients are signed q4.16, internal terms q16.16 saturating at 32 bits,
// rounding is half up. Configuration is written through a plain write port; the user
// must write it only while the unit is idle (not enforced here); there is no read-back.

module pid_controller_tustin_antiwindup_unit (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    // configuration write port
    input  logic                            i_cfg_wr_en,
    input  logic [pidt_pkg::CfgIdxW-1:0]    i_cfg_index,
    input  logic [pidt_pkg::CfgDataW-1:0]   i_cfg_data,
    // request stream
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    input  logic [pidt_pkg::InDataW-1:0]    s_axis_tdata,   // [15:0] error_in, [47:16] time_us
    input  logic                            s_axis_tuser,   // [0] operation
    // result stream
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    output logic [pidt_pkg::OutDataW-1:0]   m_axis_tdata,   // [15:0] drive
    output logic                            m_axis_tuser    // [0] updated
);
    import pidt_pkg::*;

    t_cfg    r_cfg;
    t_ctrl   w_ctrl;
    t_stat   w_stat;
    t_result w_result;
    logic    w_fire, w_idle, w_accept, w_hold, w_out_load;

    logic                   r_out_valid;
    logic signed [OutW-1:0] r_drive;
    logic                   r_updated;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.prop_gain   <= '0;
            r_cfg.integ_coef  <= '0;
            r_cfg.deriv_coef  <= '0;
            r_cfg.windup_coef <= '0;
            r_cfg.filter_coef <= '0;
            r_cfg.period_us   <= '0;
            r_cfg.out_min     <= {1'b1, {(OutW-1){1'b0}}};
            r_cfg.out_max     <= {1'b0, {(OutW-1){1'b1}}};
        end else if (i_cfg_wr_en) begin
            case (t_cfg_idx'(i_cfg_index))
                CFG_PROP_GAIN:   r_cfg.prop_gain   <= i_cfg_data[CoefW-1:0];
                CFG_INTEG_COEF:  r_cfg.integ_coef  <= i_cfg_data[CoefW-1:0];
                CFG_DERIV_COEF:  r_cfg.deriv_coef  <= i_cfg_data[CoefW-1:0];
                CFG_WINDUP_COEF: r_cfg.windup_coef <= i_cfg_data[CoefW-1:0];
                CFG_FILTER_COEF: r_cfg.filter_coef <= i_cfg_data[CoefW-1:0];
                CFG_PERIOD_US:   r_cfg.period_us   <= i_cfg_data[TimeW-1:0];
                CFG_OUT_MIN:     r_cfg.out_min     <= i_cfg_data[OutW-1:0];
                CFG_OUT_MAX:     r_cfg.out_max     <= i_cfg_data[OutW-1:0];
                default: ;
            endcase
        end
    end

    // one request in flight; accepted only while the sequencer is idle
    assign s_axis_tready = w_idle;
    assign w_accept      = s_axis_tvalid && s_axis_tready;

    // final step waits while an earlier result is still not taken
    assign w_hold     = r_out_valid && !m_axis_tready;
    assign w_out_load = w_fire && w_ctrl.done;

    pidt_seq u_seq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_accept),
        .i_hold  (w_hold),
        .i_stat  (w_stat),
        .o_ctrl  (w_ctrl),
        .o_fire  (w_fire),
        .o_idle  (w_idle)
    );

    pidt_dpath u_dpath (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cfg    (r_cfg),
        .i_load   (w_accept),
        .i_op     (s_axis_tuser),
        .i_err    (s_axis_tdata[ErrW-1:0]),
        .i_time   (s_axis_tdata[ErrW+TimeW-1:ErrW]),
        .i_ctrl   (w_ctrl),
        .i_fire   (w_fire),
        .o_stat   (w_stat),
        .o_result (w_result)
    );

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_out_load) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_out_load) begin
            r_drive   <= w_result.drive;
            r_updated <= w_result.updated;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = OutDataW'(r_drive);
    assign m_axis_tuser  = r_updated;

endmodule

// File: rtl/pidt_checker.sv
`timescale 1ns / 1ps
// pidt_checker: port-level checks of the pid unit, bound to the top level
// depends on pidt_pkg and pid_controller_tustin_antiwindup_unit

module pidt_checker (
    input logic                            i_clk,
    input logic                            i_rst_n,
    input logic                            s_axis_tvalid,
    input logic                            s_axis_tready,
    input logic                            m_axis_tvalid,
    input logic                            m_axis_tready,
    input logic [pidt_pkg::OutDataW-1:0]   m_axis_tdata,   // [15:0] drive
    input logic                            m_axis_tuser    // [0] updated
);
    import pidt_pkg::*;

    logic [OutW-1:0] r_last_drive;
    logic            w_s_acc, w_m_acc;

    assign w_s_acc = s_axis_tvalid && s_axis_tready;
    assign w_m_acc = m_axis_tvalid && m_axis_tready;

    // last delivered drive, which is the held output
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_last_drive <= '0;
        end else if (w_m_acc) begin
            r_last_drive <= m_axis_tdata[OutW-1:0];
        end
    end

    a_valid_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
        else $error("result dropped while stalled");

    a_single_request: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_s_acc |=> !s_axis_tready)
        else $error("second request taken while one is in flight");

    a_skip_repeats: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_m_acc && !m_axis_tuser |-> m_axis_tdata[OutW-1:0] == r_last_drive)
        else $error("result without update does not repeat the held output");

    a_result_from_work: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(m_axis_tvalid) |-> !$past(s_axis_tready))
        else $error("result appeared while the unit was idle");

endmodule

bind pid_controller_tustin_antiwindup_unit pidt_checker u_pidt_checker (.*);

// File: dv/pid_controller_tustin_antiwindup_unit_tb.sv
`timescale 1ns / 1ps
// pid_controller_tustin_antiwindup_unit_tb: self-checking bench for the pid unit
// depends on pidt_pkg and pid_controller_tustin_antiwindup_unit; needs no files or arguments

module pid_controller_tustin_antiwindup_unit_tb;
    import pidt_pkg::*;

    // predicts drive and updated for every accepted request and checks results in order
    class pid_drive_board;
        // register mirror
        longint    kp, ki_half, kd, kb_half, kf;
        bit [31:0] period;
        longint    lim_lo, lim_hi;
        // controller state
        longint    integ, deriv, windup_prev, err_prev, drive_held;
        bit [31:0] stamp_prev;
        t_result   drive_due[$];
        int unsigned fault_cnt, ran_cnt, held_cnt, clear_cnt;

        function new();
            kp = 0; ki_half = 0; kd = 0; kb_half = 0; kf = 0;
            period = '0;
            lim_lo = -32768;
            lim_hi = 32767;
            integ = 0; deriv = 0; windup_prev = 0; err_prev = 0; drive_held = 0;
            stamp_prev = '0;
            fault_cnt = 0; ran_cnt = 0; held_cnt = 0; clear_cnt = 0;
        endfunction

        function longint q_sat(longint x);
            if (x > 64'sd2147483647) return 64'sd2147483647;
            if (x < -64'sd2147483648) return -64'sd2147483648;
            return x;
        endfunction

        // round half up, then drop the 16 fraction bits
        function longint half_up(longint x);
            return (x + 64'sd32768) >>> 16;
        endfunction

        // lower limit tested first, so with inverted limits it wins for values below it
        function longint bound(longint x, longint lo, longint hi);
            if (x < lo) return lo;
            if (x > hi) return hi;
            return x;
        endfunction

        function void set_reg(t_cfg_idx idx, logic [31:0] v);
            case (idx)
                CFG_PROP_GAIN:   kp      = longint'($signed(v[20:0]));
                CFG_INTEG_COEF:  ki_half = longint'($signed(v[20:0]));
                CFG_DERIV_COEF:  kd      = longint'($signed(v[20:0]));
                CFG_WINDUP_COEF: kb_half = longint'($signed(v[20:0]));
                CFG_FILTER_COEF: kf      = longint'($signed(v[20:0]));
                CFG_PERIOD_US:   period  = v;
                CFG_OUT_MIN:     lim_lo  = longint'($signed(v[15:0]));
                CFG_OUT_MAX:     lim_hi  = longint'($signed(v[15:0]));
                default: ;
            endcase
        endfunction

        function void note_request(t_item_op op, logic signed [15:0] err, logic [31:0] now);
            longint    ev, p, u, aw, s, lo, hi;
            bit [31:0] elapsed;
            bit        ran;
            t_result   r;
            ev  = longint'(err);
            ran = 1'b0;
            if (op == OP_CLEAR) begin
                integ       = 0;
                windup_prev = 0;
                clear_cnt++;
            end else begin
                elapsed = now - stamp_prev;
                if (elapsed >= period) begin
                    lo    = lim_lo * 65536;
                    hi    = lim_hi * 65536;
                    p     = q_sat(kp * ev);
                    integ = q_sat(integ + ki_half * (ev + err_prev));
                    deriv = q_sat(half_up(kf * deriv) + kd * (ev - err_prev));
                    u     = q_sat(p + integ + deriv);
                    aw    = q_sat(bound(u, lo, hi) - u);
                    // back-calculation feeds the integral
                    integ = q_sat(integ + half_up(kb_half * (aw + windup_prev)));
                    s     = q_sat(p + integ + deriv);
                    drive_held  = bound(half_up(s), lim_lo, lim_hi);
                    err_prev    = ev;
                    windup_prev = aw;
                    stamp_prev  = now;
                    ran = 1'b1;
                    ran_cnt++;
                end else begin
                    held_cnt++;
                end
            end
            r.drive   = drive_held[15:0];
            r.updated = ran;
            drive_due.push_back(r);
        endfunction

        function void check_result(logic [15:0] drive, logic upd);
            t_result r;
            if (drive_due.size() == 0) begin
                $display("%0t: result with nothing pending, drive %0d updated %0b",
                         $time, $signed(drive), upd);
                fault_cnt++;
                return;
            end
            r = drive_due.pop_front();
            if (drive !== r.drive) begin
                $display("%0t: drive mismatch, expected %0d, actual %0d",
                         $time, r.drive, $signed(drive));
                fault_cnt++;
            end
            if (upd !== r.updated) begin
                $display("%0t: updated mismatch, expected %0b, actual %0b",
                         $time, r.updated, upd);
                fault_cnt++;
            end
        endfunction
    endclass

    // receiver stall patterns
    typedef enum int {
        RX_FREE,
        RX_RANDOM,
        RX_BEAT
    } t_rx_mode;

    logic                   i_clk;
    logic                   i_rst_n;
    logic                   i_cfg_wr_en;
    logic [CfgIdxW-1:0]     i_cfg_index;
    logic [CfgDataW-1:0]    i_cfg_data;
    logic                   s_axis_tvalid;
    logic                   s_axis_tready;
    logic [InDataW-1:0]     s_axis_tdata;   // [15:0] error_in, [47:16] time_us
    logic                   s_axis_tuser;   // [0] operation
    logic                   m_axis_tvalid;
    logic                   m_axis_tready;
    logic [OutDataW-1:0]    m_axis_tdata;   // [15:0] drive
    logic                   m_axis_tuser;   // [0] updated

    pid_drive_board board = new();

    int unsigned burst_left = 0;
    int unsigned sent_cnt   = 0;
    int unsigned phase_cnt  = 0;
    // each bump asks the receiver for one long hold-off
    int unsigned hold_asks  = 0;

    pid_controller_tustin_antiwindup_unit dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // hard stop well past the slowest legal run
    initial begin
        #5_000_000;
        $display("[FAIL] regression broken");
        $finish;
    end

    // result side: modes switch at random, long hold-offs on request
    initial begin
        t_rx_mode    mode;
        int unsigned mode_left, hold_left, hold_seen;
        logic        rdy;
        mode      = RX_FREE;
        mode_left = 0;
        hold_left = 0;
        hold_seen = 0;
        m_axis_tready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (mode_left == 0) begin
                case ($urandom_range(0, 2))
                    0:       mode = RX_FREE;
                    1:       mode = RX_RANDOM;
                    default: mode = RX_BEAT;
                endcase
                mode_left = $urandom_range(20, 120);
            end
            mode_left--;
            if (hold_asks != hold_seen) begin
                hold_seen = hold_asks;
                hold_left = 300;
            end
            if (hold_left > 0) begin
                hold_left--;
                rdy = 1'b0;
            end else begin
                case (mode)
                    RX_FREE:   rdy = 1'b1;
                    RX_RANDOM: rdy = ($urandom_range(0, 99) >= 35);
                    default:   rdy = ((mode_left % 5) >= 2);
                endcase
            end
            m_axis_tready <= rdy;
        end
    end

    // every accepted result goes to the scoreboard
    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            board.check_result(m_axis_tdata, m_axis_tuser);
        end
    end

    task automatic idle_cycles(int unsigned n);
        repeat (n) begin
            @(negedge i_clk);
            s_axis_tvalid <= 1'b0;
        end
    endtask

    // offers one request and returns at the edge that accepts it; valid stays
    // high so a back-to-back request needs no second assignment in one step
    task automatic send_request(t_item_op op, logic signed [15:0] err, logic [31:0] stamp);
        if (burst_left == 0) begin
            idle_cycles(($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8));
            burst_left = $urandom_range(1, 16);
        end
        burst_left--;
        @(negedge i_clk);
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {stamp, err};
        s_axis_tuser  <= op;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        board.note_request(op, err, stamp);
        sent_cnt++;
    endtask

    // stop offering, wait for every pending result, then let the unit settle
    task automatic drain_results();
        int unsigned waited;
        idle_cycles(1);
        waited = 0;
        while (board.drive_due.size() != 0 && waited < 50000) begin
            @(posedge i_clk);
            waited++;
        end
        if (board.drive_due.size() != 0) begin
            $display("%0t: %0d results never arrived", $time, board.drive_due.size());
            board.fault_cnt++;
        end
        repeat (16) @(posedge i_clk);
    endtask

    task automatic write_reg(t_cfg_idx idx, logic [31:0] val);
        @(negedge i_clk);
        i_cfg_wr_en <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        board.set_reg(idx, val);
    endtask

    // writes all eight registers back to back; only called with the unit idle
    task automatic load_config(t_cfg c);
        write_reg(CFG_PROP_GAIN,   32'(c.prop_gain));
        write_reg(CFG_INTEG_COEF,  32'(c.integ_coef));
        write_reg(CFG_DERIV_COEF,  32'(c.deriv_coef));
        write_reg(CFG_WINDUP_COEF, 32'(c.windup_coef));
        write_reg(CFG_FILTER_COEF, 32'(c.filter_coef));
        write_reg(CFG_PERIOD_US,   c.period_us);
        write_reg(CFG_OUT_MIN,     32'(c.out_min));
        write_reg(CFG_OUT_MAX,     32'(c.out_max));
        @(negedge i_clk);
        i_cfg_wr_en <= 1'b0;
        phase_cnt++;
    endtask

    function automatic t_cfg make_cfg(int kp, int ki, int kd, int kb, int kf,
                                      logic [31:0] per, int lo, int hi);
        t_cfg c;
        c.prop_gain   = 21'(kp);
        c.integ_coef  = 21'(ki);
        c.deriv_coef  = 21'(kd);
        c.windup_coef = 21'(kb);
        c.filter_coef = 21'(kf);
        c.period_us   = per;
        c.out_min     = 16'(lo);
        c.out_max     = 16'(hi);
        return c;
    endfunction

    // wide settings cover every coefficient bit; narrow ones keep the loop
    // mostly inside its limits so the integral and derivative stay visible
    function automatic t_cfg rand_config(bit wide);
        t_cfg        c;
        int          lo, hi, tmp;
        logic [31:0] per;
        case ($urandom_range(0, 3))
            0:       per = '0;
            1:       per = $urandom_range(1, 200);
            2:       per = $urandom_range(200, 5000);
            default: per = $urandom;
        endcase
        lo = -int'($urandom_range(0, 32768));
        hi = int'($urandom_range(0, 32767));
        case ($urandom_range(0, 5))
            0: begin
                // inverted limits
                tmp = lo;
                lo  = hi;
                hi  = tmp;
            end
            1: begin
                lo = -32768;
                hi = 32767;
            end
            default: ;
        endcase
        if (wide) begin
            c = make_cfg(int'($urandom), int'($urandom), int'($urandom), int'($urandom),
                         int'($urandom), per, lo, hi);
        end else begin
            c = make_cfg(int'($urandom_range(0, 196608)) - 65536,
                         int'($urandom_range(0, 16384)) - 8192,
                         int'($urandom_range(0, 65536)) - 32768,
                         int'($urandom_range(0, 32768)) - 4096,
                         int'($urandom_range(0, 65536)) - 8192,
                         per, lo, hi);
        end
        return c;
    endfunction

    // timestamps sit mostly around the period boundary, measured from the
    // last update that ran; a few jump anywhere, which also wraps the counter
    function automatic logic [31:0] pick_stamp();
        logic [31:0] base, per;
        int unsigned r;
        base = board.stamp_prev;
        per  = board.period;
        r    = $urandom_range(0, 99);
        if (r < 62) return base + per + $urandom_range(0, 40);
        if (r < 77 && per != 0) return base + $urandom_range(0, per - 1);
        if (r < 84) return base + per;
        if (r < 90 && per != 0) return base + per - 1;
        return $urandom;
    endfunction

    function automatic logic signed [15:0] pick_error();
        int unsigned r;
        r = $urandom_range(0, 99);
        case (r % 4)
            0: if (r < 10) return 16'sh8000;
            1: if (r < 10) return 16'sh7fff;
            2: if (r < 10) return 16'sh0000;
            default: if (r < 10) return 16'shffff;
        endcase
        if (r < 30) return 16'($urandom);
        return 16'(int'($urandom_range(0, 4000)) - 2000);
    endfunction

    initial begin
        t_item_op    op;
        int unsigned ph, k;
        i_rst_n       = 1'b0;
        i_cfg_wr_en   = 1'b0;
        i_cfg_index   = '0;
        i_cfg_data    = '0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = 1'b0;
        repeat (10) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // reset settings: zero gains, zero period, so the law runs and gives 0
        send_request(OP_UPDATE, 16'sd500, 32'd0);
        drain_results();

        // moderate loop: too early, backwards time, clear, timestamp wrap,
        // exact period boundary
        load_config(make_cfg(65536, 3277, 13107, 6554, 32768, 32'd100, -1000, 1000));
        send_request(OP_UPDATE, 16'sd100,    32'd100);
        send_request(OP_UPDATE, 16'sd32767,  32'd200);
        send_request(OP_UPDATE, 16'sd5,      32'd250);
        send_request(OP_UPDATE, -16'sd32768, 32'd300);
        send_request(OP_UPDATE, 16'sd0,      32'd299);
        send_request(OP_CLEAR,  16'sd77,     32'd10);
        send_request(OP_UPDATE, -16'sd1,     32'hffff_ffc0);
        send_request(OP_UPDATE, 16'sd7,      32'h0000_0030);
        send_request(OP_UPDATE, 16'sd7,      32'h0000_0040);
        send_request(OP_UPDATE, 16'sd1234,   32'h0000_0094);
        drain_results();

        // inverted limits: values below the lower limit give it, all others the upper limit
        load_config(make_cfg(65536, 3277, 13107, 6554, 32768, 32'd100, 500, -500));
        send_request(OP_UPDATE, 16'sd1000,  board.stamp_prev + 200);
        send_request(OP_UPDATE, -16'sd1000, board.stamp_prev + 200);
        send_request(OP_UPDATE, 16'sd0,     board.stamp_prev + 200);
        drain_results();

        // largest coefficients and the longest period: only an elapsed time of
        // all ones lets the law run; internal terms saturate
        load_config(make_cfg(1048575, 1048575, 1048575, 1048575, 1048575,
                             32'hffff_ffff, -32768, 32767));
        send_request(OP_UPDATE, 16'sd32767,  board.stamp_prev - 1);
        send_request(OP_UPDATE, 16'sd32767,  board.stamp_prev + 3);
        send_request(OP_UPDATE, -16'sd32768, board.stamp_prev - 1);
        send_request(OP_CLEAR,  -16'sd32768, 32'hffff_ffff);
        send_request(OP_UPDATE, 16'sd32767,  board.stamp_prev - 1);
        drain_results();

        // most negative coefficients, no period
        load_config(make_cfg(-1048576, -1048576, -1048576, -1048576, -1048576,
                             32'd0, -32768, 32767));
        send_request(OP_UPDATE, -16'sd32768, 32'h8000_0000);
        send_request(OP_UPDATE, 16'sd32767,  32'h0000_0001);
        send_request(OP_UPDATE, -16'sd32768, 32'h0000_0001);
        send_request(OP_UPDATE, 16'sd0,      32'h7fff_ffff);
        drain_results();

        // random part: ten settings, about 85 requests each
        for (ph = 0; ph < 10; ph++) begin
            load_config(rand_config(ph % 3 == 0));
            for (k = 0; k < 85; k++) begin
                // long receiver hold-off while requests keep coming, so the
                // output register fills and the request side stalls
                if ((ph == 2 || ph == 6) && k == 30) hold_asks++;
                // sender pause until everything is back
                if (ph == 4 && k == 40) drain_results();
                op = ($urandom_range(0, 99) < 8) ? OP_CLEAR : OP_UPDATE;
                send_request(op, pick_error(), pick_stamp());
            end
            drain_results();
        end

        $display("covered %0d requests over %0d register settings", sent_cnt, phase_cnt);
        $display("law ran %0d times, held %0d times, %0d integral clears",
                 board.ran_cnt, board.held_cnt, board.clear_cnt);
        if (board.fault_cnt == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
